/* hw/rtl/rgbhsv_pkg.sv */
// Shared widths, constants and types for the RGB to HSV converter.
// Used by rgbhsv_div and rgb_to_hsv_converter_unit; depends on nothing.
`default_nettype none

package rgbhsv_pkg;

  // Widths of the pixel channels and of the hue result.
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 9;

  // Divider shape: numerators are below 2^18, divisors are twice a channel
  // value and the quotient never exceeds 360.
  localparam int NUM_W = 18;
  localparam int DEN_W = 9;
  localparam int QUO_W = 9;

  // Rounded hue that lands on a full turn wraps back to zero.
  localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;

  // Channel that holds the maximum, red tested first.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

endpackage

`default_nettype wire

/* hw/rtl/rgbhsv_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Uses widths from rgbhsv_pkg as defaults; no other dependencies.
`default_nettype none

module rgbhsv_div #(
  parameter int NUM_W = rgbhsv_pkg::NUM_W,
  parameter int DEN_W = rgbhsv_pkg::DEN_W,
  parameter int QUO_W = rgbhsv_pkg::QUO_W
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0] in_den,
  output logic      [QUO_W-1:0] out_quo
);

  // The caller guarantees the quotient fits in QUO_W bits, so the partial
  // remainder always stays below the divisor shifted by the current bit.
  localparam int CW = DEN_W + QUO_W;

  logic [CW-1:0]    rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int BIT = QUO_W - 1 - k;

    logic [CW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [CW-1:0]    den_sh;
    logic             ge;
    logic [CW-1:0]    rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = CW'(in_num);
      assign den_in = in_den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      den_sh  = CW'(den_in) << BIT;
      ge      = (rem_in >= den_sh);
      rem_nxt = ge ? (rem_in - den_sh) : rem_in;
      quo_nxt = quo_in;
      quo_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_in;
      quo_r[k] <= quo_nxt;
    end
  end

  assign out_quo = quo_r[QUO_W-1];

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsv_converter_unit.sv */
// Top level of the RGB to HSV converter: channel sort, numerators and
// two pipelined dividers. Depends on rgbhsv_pkg and rgbhsv_div.
`default_nettype none

// How to use this block:
// A pixel is offered on in_red, in_green and in_blue with start high. The
// transfer happens at a rising edge where start is high and busy is low.
// busy is always low: the pipeline takes a new pixel in every cycle.
// Each result shows on out_hue, out_saturation, out_brightness and
// out_hue_defined for exactly one cycle, marked by out_valid. Between its
// input transfer and out_valid it passes stage 1, stage 2, the divider
// stages and the output register. Results leave in input order.
// Throughput is one pixel per clock. The pipeline is built from the two
// 9-stage dividers (one quotient bit per stage) plus one stage for the
// channel sort, one for the two numerators and one output register.
// The receiver cannot stall, so the pipeline never holds; it simply
// advances every clock and valid bits travel with the data.
// A synchronous reset (rst_n low) clears every valid bit, so no result
// strobe appears until a pixel transferred after reset has come through.
// Grey and black pixels give saturation 0, hue 0 and out_hue_defined 0.

module rgb_to_hsv_converter_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]  in_red,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]  in_green,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]  in_blue,
  output logic                                out_valid,
  output logic      [rgbhsv_pkg::HUE_W-1:0]   out_hue,
  output logic      [rgbhsv_pkg::CHAN_W-1:0]  out_saturation,
  output logic      [rgbhsv_pkg::CHAN_W-1:0]  out_brightness,
  output logic                                out_hue_defined
);

  localparam int CW  = rgbhsv_pkg::CHAN_W;
  localparam int NW  = rgbhsv_pkg::NUM_W;
  localparam int DW  = rgbhsv_pkg::DEN_W;
  localparam int QW  = rgbhsv_pkg::QUO_W;
  localparam int DLY = QW;

  // The pipeline never stalls, so a transfer is simply start.
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start & ~busy;

  // ---------------------------------------------------------------
  // Stage 1: find max and min, pick the sector and the channel
  // difference that drives the hue inside that sector.
  // ---------------------------------------------------------------
  logic [CW-1:0]       mx_c, mn_c;
  rgbhsv_pkg::sector_t sect_c;
  logic signed [CW:0]  diff_c;

  always_comb begin
    mx_c = (in_red > in_green) ? in_red : in_green;
    mx_c = (in_blue > mx_c) ? in_blue : mx_c;
    mn_c = (in_red < in_green) ? in_red : in_green;
    mn_c = (in_blue < mn_c) ? in_blue : mn_c;
    if (in_red == mx_c) begin
      sect_c = rgbhsv_pkg::SECT_RED;
      diff_c = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green == mx_c) begin
      sect_c = rgbhsv_pkg::SECT_GREEN;
      diff_c = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      sect_c = rgbhsv_pkg::SECT_BLUE;
      diff_c = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
  end

  logic                s1_vld_r;
  logic [CW-1:0]       s1_mx_r;
  logic [CW-1:0]       s1_d_r;
  rgbhsv_pkg::sector_t s1_sect_r;
  logic signed [CW:0]  s1_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx_r   <= mx_c;
    s1_d_r    <= mx_c - mn_c;
    s1_sect_r <= sect_c;
    s1_diff_r <= diff_c;
  end

  // ---------------------------------------------------------------
  // Stage 2: build both rounded-division numerators and divisors.
  // Hue numerator is 60*(offset + diff), lifted by a full turn when
  // negative; rounding half up becomes (2n + d) / (2d).
  // Saturation is (510*d + max) / (2*max).
  // ---------------------------------------------------------------
  logic [CW+1:0]        off_c;
  logic signed [11:0]   term_c;
  logic signed [NW-1:0] num_c;
  logic [NW-2:0]        turn_c;
  logic [NW-2:0]        wrap_c;
  logic [NW-1:0]        hue_num_c;
  logic [NW-1:0]        sat_num_c;

  always_comb begin
    case (s1_sect_r)
      rgbhsv_pkg::SECT_RED:   off_c = '0;
      rgbhsv_pkg::SECT_GREEN: off_c = {1'b0, s1_d_r, 1'b0};
      rgbhsv_pkg::SECT_BLUE:  off_c = {s1_d_r, 2'b00};
      default:                off_c = '0;
    endcase
    term_c = $signed({2'b00, off_c}) + $signed({{3{s1_diff_r[CW]}}, s1_diff_r});
    num_c  = $signed({{(NW-12){term_c[11]}}, term_c}) * $signed(NW'(60));
    turn_c = (NW-1)'(s1_d_r) * (NW-1)'(360);
    if (num_c[NW-1]) begin
      wrap_c = (NW-1)'(num_c) + turn_c;
    end else begin
      wrap_c = (NW-1)'(num_c);
    end
    hue_num_c = {wrap_c, 1'b0} + NW'(s1_d_r);
    sat_num_c = NW'(s1_d_r) * NW'(510) + NW'(s1_mx_r);
  end

  logic          s2_vld_r;
  logic [CW-1:0] s2_mx_r;
  logic          s2_def_r;
  logic [NW-1:0] s2_hue_num_r;
  logic [DW-1:0] s2_hue_den_r;
  logic [NW-1:0] s2_sat_num_r;
  logic [DW-1:0] s2_sat_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // Saturation is nonzero exactly when max and min differ.
  always_ff @(posedge clk) begin
    s2_mx_r      <= s1_mx_r;
    s2_def_r     <= (s1_d_r != '0);
    s2_hue_num_r <= hue_num_c;
    s2_hue_den_r <= {s1_d_r, 1'b0};
    s2_sat_num_r <= sat_num_c;
    s2_sat_den_r <= {s1_mx_r, 1'b0};
  end

  // ---------------------------------------------------------------
  // Dividers: both run the same number of stages so their quotients
  // come out together. A zero divisor only occurs when the result is
  // masked afterwards.
  // ---------------------------------------------------------------
  logic [QW-1:0] hue_quo;
  logic [QW-1:0] sat_quo;

  rgbhsv_div #(
    .NUM_W (NW),
    .DEN_W (DW),
    .QUO_W (QW)
  ) u_hue_div (
    .clk     (clk),
    .in_num  (s2_hue_num_r),
    .in_den  (s2_hue_den_r),
    .out_quo (hue_quo)
  );

  rgbhsv_div #(
    .NUM_W (NW),
    .DEN_W (DW),
    .QUO_W (QW)
  ) u_sat_div (
    .clk     (clk),
    .in_num  (s2_sat_num_r),
    .in_den  (s2_sat_den_r),
    .out_quo (sat_quo)
  );

  // Side data that rides alongside the divider stages.
  logic          vld_dly_r [DLY];
  logic          def_dly_r [DLY];
  logic [CW-1:0] mx_dly_r  [DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) begin
        vld_dly_r[i] <= 1'b0;
      end
    end else begin
      vld_dly_r[0] <= s2_vld_r;
      for (int i = 1; i < DLY; i++) begin
        vld_dly_r[i] <= vld_dly_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    def_dly_r[0] <= s2_def_r;
    mx_dly_r[0]  <= s2_mx_r;
    for (int i = 1; i < DLY; i++) begin
      def_dly_r[i] <= def_dly_r[i-1];
      mx_dly_r[i]  <= mx_dly_r[i-1];
    end
  end

  // ---------------------------------------------------------------
  // Output stage: wrap a hue of a full turn to zero and clear hue and
  // saturation for grey or black pixels.
  // ---------------------------------------------------------------
  logic                         def_c;
  logic [rgbhsv_pkg::HUE_W-1:0] hue_c;
  logic [CW-1:0]                sat_c;

  always_comb begin
    def_c = def_dly_r[DLY-1];
    if (!def_c || (hue_quo == rgbhsv_pkg::HUE_WRAP)) begin
      hue_c = '0;
    end else begin
      hue_c = hue_quo;
    end
    sat_c = def_c ? sat_quo[CW-1:0] : '0;
  end

  logic                         out_valid_r;
  logic [rgbhsv_pkg::HUE_W-1:0] out_hue_r;
  logic [CW-1:0]                out_sat_r;
  logic [CW-1:0]                out_bri_r;
  logic                         out_def_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_dly_r[DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    out_hue_r <= hue_c;
    out_sat_r <= sat_c;
    out_bri_r <= mx_dly_r[DLY-1];
    out_def_r <= def_c;
  end

  assign out_valid       = out_valid_r;
  assign out_hue         = out_hue_r;
  assign out_saturation  = out_sat_r;
  assign out_brightness  = out_bri_r;
  assign out_hue_defined = out_def_r;

endmodule

`default_nettype wire

/* tb/rgb_to_hsv_converter_unit_test.sv */
// Self-checking testbench for rgb_to_hsv_converter_unit: directed pixels from a table,
// then random pixels, each result checked against a built-in HSV predictor.
// Depends on rgbhsv_pkg and the converter RTL.
module rgb_to_hsv_converter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_W = rgbhsv_pkg::CHAN_W;
  localparam int HUE_W  = rgbhsv_pkg::HUE_W;

  // Full-scale channel value, degrees per hue sector, and how many random pixels to send.
  localparam int CHAN_MAX       = 255;
  localparam int DEG_PER_SECTOR = 60;
  localparam int RANDOM_PIXELS  = 550;
  // The drain window keeps watching after the last result. The cycle limit
  // allows a long gap before every pixel with a wide margin on top.
  localparam int DRAIN_CYCLES   = 24;
  localparam int CYCLE_LIMIT    = 400000;

  // One converted pixel, field for field as the result ports carry it.
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
    logic              hue_defined;
  } hsv_t;

  // One row of the directed table. When typed is set, the expected result
  // is given in the row. When it is clear, the predictor supplies it.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              typed;
    hsv_t              want;
  } pixel_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CHAN_W-1:0] in_red = '0;
  logic [CHAN_W-1:0] in_green = '0;
  logic [CHAN_W-1:0] in_blue = '0;
  logic              out_valid;
  logic [HUE_W-1:0]  out_hue;
  logic [CHAN_W-1:0] out_saturation;
  logic [CHAN_W-1:0] out_brightness;
  logic              out_hue_defined;

  // These signals travel with the pixel being offered. They tell the
  // monitor whether the expected result comes from the table.
  logic              offer_typed = 1'b0;
  hsv_t              offer_want = '0;

  hsv_t              pending_hsv[$];
  int unsigned       cycle_count = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       pixels_sent = 0;
  int unsigned       results_checked = 0;
  int unsigned       undefined_hue_seen = 0;

  // Directed pixels. These cover black, white and greys, the six pure
  // hues, the smallest nonzero saturation, a saturation tie that rounds
  // up, and a negative red-sector hue that rounds up to a full turn and
  // wraps to zero. Ties between the maximum channels test the rule that
  // red is tested first, then green.
  pixel_row_t directed_rows [24] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   8'd0,   1'b0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   8'd0,   8'd255, 1'b0}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{9'd0,   8'd0,   8'd128, 1'b0}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{9'd0,   8'd0,   8'd1,   1'b0}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd255, 1'b1}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 8'd255, 8'd255, 1'b1}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 8'd255, 8'd255, 1'b1}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  8'd255, 8'd255, 1'b1}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 8'd255, 8'd255, 1'b1}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 8'd255, 8'd255, 1'b1}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd1,   1'b1}},
    '{8'd255, 8'd254, 8'd254, 1'b1, '{9'd0,   8'd1,   8'd255, 1'b1}},
    '{8'd2,   8'd1,   8'd1,   1'b1, '{9'd0,   8'd128, 8'd2,   1'b1}},
    '{8'd255, 8'd0,   8'd1,   1'b1, '{9'd0,   8'd255, 8'd255, 1'b1}},
    '{8'd200, 8'd50,  8'd100, 1'b0, '0},
    '{8'd10,  8'd200, 8'd30,  1'b0, '0},
    '{8'd30,  8'd10,  8'd200, 1'b0, '0},
    '{8'd255, 8'd128, 8'd0,   1'b0, '0},
    '{8'd17,  8'd34,  8'd51,  1'b0, '0},
    '{8'd254, 8'd255, 8'd253, 1'b0, '0},
    '{8'd100, 8'd100, 8'd50,  1'b0, '0},
    '{8'd50,  8'd100, 8'd100, 1'b0, '0},
    '{8'd0,   8'd1,   8'd255, 1'b0, '0},
    '{8'd128, 8'd64,  8'd127, 1'b0, '0}
  };

  rgb_to_hsv_converter_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_hue         (out_hue),
    .out_saturation  (out_saturation),
    .out_brightness  (out_brightness),
    .out_hue_defined (out_hue_defined)
  );

  always #5 clk = ~clk;

  // Predicts the HSV result of one pixel with exact integer rounding.
  // Each quotient n/d is rounded half up as (2n + d) / (2d). In the red
  // sector a negative hue gets a full turn added before it is rounded, and
  // a rounded hue that reaches a full turn wraps to zero.
  function automatic hsv_t convert_pixel(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                         logic [CHAN_W-1:0] blue);
    int                  r;
    int                  g;
    int                  b;
    int                  top;
    int                  bottom;
    int                  span;
    int                  hue_num;
    rgbhsv_pkg::sector_t sector;
    hsv_t                res;
    r = int'(red);
    g = int'(green);
    b = int'(blue);
    top = (r > g) ? r : g;
    top = (b > top) ? b : top;
    bottom = (r < g) ? r : g;
    bottom = (b < bottom) ? b : bottom;
    span = top - bottom;
    res = '0;
    res.brightness = CHAN_W'(top);
    if (top != 0) begin
      res.saturation = CHAN_W'((2 * CHAN_MAX * span + top) / (2 * top));
    end
    if (res.saturation != 0) begin
      res.hue_defined = 1'b1;
      if (r == top) begin
        sector = rgbhsv_pkg::SECT_RED;
      end else if (g == top) begin
        sector = rgbhsv_pkg::SECT_GREEN;
      end else begin
        sector = rgbhsv_pkg::SECT_BLUE;
      end
      case (sector)
        rgbhsv_pkg::SECT_RED: begin
          hue_num = DEG_PER_SECTOR * (g - b);
        end
        rgbhsv_pkg::SECT_GREEN: begin
          hue_num = DEG_PER_SECTOR * (2 * span + (b - r));
        end
        default: begin
          hue_num = DEG_PER_SECTOR * (4 * span + (r - g));
        end
      endcase
      if (hue_num < 0) begin
        hue_num += int'(rgbhsv_pkg::HUE_WRAP) * span;
      end
      res.hue = HUE_W'(((2 * hue_num + span) / (2 * span)) % int'(rgbhsv_pkg::HUE_WRAP));
    end
    return res;
  endfunction

  // Reports one field that does not match the expected value.
  task automatic report_field(string field, int want, int got);
    $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // Offers one pixel and holds it until the transfer happens. Start stays
  // high when the caller offers another pixel right after this one.
  task automatic offer_pixel(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                             logic [CHAN_W-1:0] blue, logic typed, hsv_t want);
    start       <= 1'b1;
    in_red      <= red;
    in_green    <= green;
    in_blue     <= blue;
    offer_typed <= typed;
    offer_want  <= want;
    do @(posedge clk); while (busy);
    pixels_sent++;
  endtask

  // Pauses the sender. Most gaps are short and a few are long. During a
  // gap the channels carry random values, which the block must ignore.
  // The caller forces a run of back-to-back transfers with no_gap.
  task automatic sender_gap(bit no_gap);
    int pick;
    int cycles;
    pick = $urandom_range(0, 99);
    if (no_gap || pick < 55) begin
      cycles = 0;
    end else if (pick < 85) begin
      cycles = $urandom_range(1, 3);
    end else if (pick < 97) begin
      cycles = $urandom_range(4, 10);
    end else begin
      cycles = $urandom_range(20, 60);
    end
    if (cycles > 0) begin
      start    <= 1'b0;
      in_red   <= CHAN_W'($urandom);
      in_green <= CHAN_W'($urandom);
      in_blue  <= CHAN_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // This monitor sees both channels at the same edge. It records each
  // transfer first, then checks any result strobe against the oldest
  // pending expectation. The block's outputs change by nonblocking updates,
  // so the values read here are the ones held during the cycle that just
  // ended.
  always @(posedge clk) begin
    hsv_t want;
    if (rst_n) begin
      if (start && !busy) begin
        pending_hsv.push_back(offer_typed ? offer_want
                                          : convert_pixel(in_red, in_green, in_blue));
      end
      if (out_valid) begin
        if (pending_hsv.size() == 0) begin
          $display("%0t ns: result strobe with nothing pending: expected none, actual %0d/%0d/%0d/%0d",
                   $time, out_hue, out_saturation, out_brightness, out_hue_defined);
          mismatch_count++;
        end else begin
          want = pending_hsv.pop_front();
          results_checked++;
          if (!want.hue_defined) begin
            undefined_hue_seen++;
          end
          if (out_hue !== want.hue) begin
            report_field("hue", int'(want.hue), int'(out_hue));
          end
          if (out_saturation !== want.saturation) begin
            report_field("saturation", int'(want.saturation), int'(out_saturation));
          end
          if (out_brightness !== want.brightness) begin
            report_field("brightness", int'(want.brightness), int'(out_brightness));
          end
          if (out_hue_defined !== want.hue_defined) begin
            report_field("hue_defined", int'(want.hue_defined), int'(out_hue_defined));
          end
        end
      end
    end
  end

  // This watchdog ends a run that hangs, for example if busy never drops
  // or results stop arriving.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count,
               pending_hsv.size());
      $display("rgb_to_hsv_converter_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int          kind;
    int          base;
    logic [CHAN_W-1:0] chan [3];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table. Gaps are random here too.
    foreach (directed_rows[i]) begin
      offer_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                  directed_rows[i].typed, directed_rows[i].want);
      sender_gap(1'b0);
    end

    // Random part. Most pixels are fully random. The rest are greys,
    // near-greys whose small spread stresses the saturation and hue
    // rounding, and pixels whose channels sit at 0 or 255 so that exact
    // sector edges and ties for the maximum come up often. In every
    // hundred pixels, the first quarter goes back to back.
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          chan[0] = CHAN_W'($urandom);
          chan[1] = chan[0];
          chan[2] = chan[0];
        end
        1: begin
          base = $urandom_range(0, CHAN_MAX - 3);
          foreach (chan[c]) chan[c] = CHAN_W'(base + int'($urandom_range(0, 3)));
        end
        2: begin
          foreach (chan[c]) begin
            case ($urandom_range(0, 2))
              0: chan[c] = '0;
              1: chan[c] = CHAN_W'(CHAN_MAX);
              default: chan[c] = CHAN_W'($urandom);
            endcase
          end
        end
        default: begin
          foreach (chan[c]) chan[c] = CHAN_W'($urandom);
        end
      endcase
      offer_pixel(chan[0], chan[1], chan[2], 1'b0, '0);
      sender_gap((n % 100) < 25);
    end
    start <= 1'b0;

    // Wait for the pipeline to drain. Then keep watching for a while so
    // that a spurious extra strobe would still be caught.
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels and checked %0d results, %0d of them with undefined hue.",
             pixels_sent, results_checked, undefined_hue_seen);
    $display("Coverage: greys, pure hues, sector ties, rounding ties, hue wrap, random gaps.");
    if (mismatch_count == 0 && pending_hsv.size() == 0) begin
      $display("rgb_to_hsv_converter_unit regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               pending_hsv.size());
      $display("rgb_to_hsv_converter_unit regression: fail");
    end
    $finish;
  end

endmodule
